[rtl/core/tmis_pkg.sv]
// shared types and constants for the toric minimum inversion scanner
package tmis_pkg;

    localparam int unsigned MAX_LEN = 16;
    localparam logic [4:0] SIZE_LOW = 5'd3;
    localparam logic [4:0] SIZE_HIGH = 5'd16;
    localparam logic [4:0] SIZE_RESET = 5'd8;
    localparam logic [4:0] COUNT_MAX = 5'd31;
    localparam logic [8:0] FEWEST_NONE = 9'd511;
    localparam logic [6:0] MIN_INIT = 7'd127;
    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
    localparam int unsigned QUEUE_DEPTH = 4;

    // one classified word from the front end
    typedef struct packed {
        logic       wr;
        logic [3:0] idx;
        logic [3:0] value;
        logic       last;
        logic       ok;
    } t_entry;

    typedef enum logic [1:0] {
        S_LOAD,
        S_BASE,
        S_SCAN
    } t_state;

endpackage

[rtl/core/toric_min_inversion_scan.sv]
// top level of the toric minimum inversion scanner
// Words (one permutation entry each) are taken one per cycle, while the
// four-word queue is not full; busy rises only while that queue is full. The
// back end stores each entry as it leaves the queue, and after the final entry
// of a well formed permutation of length n it runs the plain inversion count
// (one row per cycle) and then the cut table (one entry per cycle). A
// malformed permutation returns its result in the cycle after its final entry
// leaves the queue. Each result is held on the outputs for exactly one cycle
// while o_done is high and must be taken then. Writing the size register
// clears the running aggregates and any partly loaded permutation; write it
// only while the block is idle.
module toric_min_inversion_scan
    import tmis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_element_value,
    input  logic        i_last_element,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [6:0]  o_min_inversions,
    output logic [8:0]  o_good_cut_count,
    output logic [6:0]  o_best_min_inversions,
    output logic [47:0] o_best_count,
    output logic [8:0]  o_fewest_good_cuts,
    output logic [47:0] o_permutations_seen,
    output logic        o_bad_permutation
);

    logic [4:0] r_size;
    logic       accept;
    logic       full, empty, pop;
    t_entry     front_entry, queue_entry;

    assign accept = start && !full;
    assign busy = full;

    // size register with clamping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_wdata < SIZE_LOW) begin
                r_size <= SIZE_LOW;
            end else if (i_cfg_wdata > SIZE_HIGH) begin
                r_size <= SIZE_HIGH;
            end else begin
                r_size <= i_cfg_wdata;
            end
        end
    end

    tmis_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (i_cfg_we),
        .i_size          (r_size),
        .i_accept        (accept),
        .i_element_value (i_element_value),
        .i_last_element  (i_last_element),
        .o_entry         (front_entry)
    );

    tmis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (queue_entry),
        .o_empty (empty),
        .o_full  (full)
    );

    tmis_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_clear               (i_cfg_we),
        .i_size                (r_size),
        .i_entry               (queue_entry),
        .i_empty               (empty),
        .o_pop                 (pop),
        .o_done                (o_done),
        .o_min_inversions      (o_min_inversions),
        .o_good_cut_count      (o_good_cut_count),
        .o_best_min_inversions (o_best_min_inversions),
        .o_best_count          (o_best_count),
        .o_fewest_good_cuts    (o_fewest_good_cuts),
        .o_permutations_seen   (o_permutations_seen),
        .o_bad_permutation     (o_bad_permutation)
    );

endmodule

[rtl/core/tmis_front.sv]
// front end: counts and checks incoming words and classifies them
module tmis_front
    import tmis_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic [4:0] i_size,
    input  logic       i_accept,
    input  logic [3:0] i_element_value,
    input  logic       i_last_element,
    output t_entry     o_entry
);

    logic [4:0]  r_count, n_count;
    logic [15:0] r_seen, n_seen;
    logic [15:0] seen_upd;
    logic [15:0] full_mask;

    // seen mask and load count after this word
    always_comb begin
        seen_upd = r_seen;
        if ({1'b0, i_element_value} < i_size) begin
            seen_upd[i_element_value] = 1'b1;
        end
        full_mask = 16'((17'd1 << i_size) - 17'd1);
        o_entry.wr = (r_count < 5'(MAX_LEN));
        o_entry.idx = r_count[3:0];
        o_entry.value = i_element_value;
        o_entry.last = i_last_element;
        o_entry.ok = ((r_count + 5'd1) == i_size) && (seen_upd == full_mask);
        n_count = r_count;
        n_seen = r_seen;
        if (i_clear) begin
            n_count = '0;
            n_seen = '0;
        end else if (i_accept) begin
            if (i_last_element) begin
                n_count = '0;
                n_seen = '0;
            end else begin
                n_count = (r_count < COUNT_MAX) ? r_count + 5'd1 : r_count;
                n_seen = seen_upd;
            end
        end
    end

    // counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seen <= '0;
        end else begin
            r_count <= n_count;
            r_seen <= n_seen;
        end
    end

endmodule

[rtl/core/tmis_queue.sv]
// short queue of classified words between front and back
module tmis_queue
    import tmis_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_empty,
    output logic   o_full
);

    t_entry     r_mem [QUEUE_DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_entry = r_mem[r_rp];
    assign o_empty = (r_cnt == 3'd0);
    assign o_full = (r_cnt == 3'(QUEUE_DEPTH));

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

endmodule

[rtl/core/tmis_back.sv]
// back end: stores the permutation, scans all cuts, keeps aggregates
module tmis_back
    import tmis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic [4:0]  i_size,
    input  t_entry      i_entry,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_done,
    output logic [6:0]  o_min_inversions,
    output logic [8:0]  o_good_cut_count,
    output logic [6:0]  o_best_min_inversions,
    output logic [47:0] o_best_count,
    output logic [8:0]  o_fewest_good_cuts,
    output logic [47:0] o_permutations_seen,
    output logic        o_bad_permutation
);

    logic [3:0] r_perm [MAX_LEN];
    logic [3:0] r_inv [MAX_LEN];

    t_state      r_state, n_state;
    logic [3:0]  r_i, n_i, r_a, n_a, r_s, n_s;
    logic [6:0]  r_acc, n_acc, r_col0, n_col0, r_cur, n_cur;
    logic [6:0]  r_min, n_min;
    logic [8:0]  r_good, n_good;
    logic [5:0]  r_target, n_target;
    logic        r_done, n_done;
    logic [6:0]  r_omin, n_omin;
    logic [8:0]  r_ogood, n_ogood;
    logic        r_obad, n_obad;
    logic [6:0]  r_best, n_best;
    logic [47:0] r_bcnt, n_bcnt;
    logic [8:0]  r_fewest, n_fewest;
    logic [47:0] r_total, n_total;

    logic [4:0]  cnt_gt;
    logic [4:0]  diff;
    logic [3:0]  p;
    logic [8:0]  cur_step, col_step;
    logic [6:0]  emin;
    logic [8:0]  egood;
    logic [9:0]  sq;

    assign o_pop = (r_state == S_LOAD) && !i_empty;

    // inversion, step and cut evaluation datapath
    always_comb begin
        cnt_gt = '0;
        for (int j = 0; j < MAX_LEN; j++) begin
            if ((5'(j) > {1'b0, r_i}) && (5'(j) < i_size) && (r_perm[r_i] > r_perm[j])) begin
                cnt_gt = cnt_gt + 5'd1;
            end
        end
        diff = {1'b0, r_inv[r_s]} - {1'b0, r_a};
        p = diff[4] ? 4'(diff + i_size) : diff[3:0];
        cur_step = {2'b0, r_cur} + {4'b0, i_size} - 9'd1 - {4'b0, p, 1'b0};
        col_step = {2'b0, r_col0} + {4'b0, i_size} - 9'd1 - {4'b0, r_perm[r_a], 1'b0};
        emin = (r_cur < r_min) ? r_cur : r_min;
        egood = r_good + (({1'b0, r_cur} <= {2'b0, r_target}) ? 9'd1 : 9'd0);
        sq = 10'({5'b0, i_size - 5'd1} * {5'b0, i_size - 5'd1});
    end

    // sequencer and aggregates
    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_a = r_a;
        n_s = r_s;
        n_acc = r_acc;
        n_col0 = r_col0;
        n_cur = r_cur;
        n_min = r_min;
        n_good = r_good;
        n_target = r_target;
        n_done = 1'b0;
        n_omin = r_omin;
        n_ogood = r_ogood;
        n_obad = r_obad;
        n_best = r_best;
        n_bcnt = r_bcnt;
        n_fewest = r_fewest;
        n_total = r_total;
        case (r_state)
            S_LOAD: begin
                if (o_pop && i_entry.last) begin
                    if (i_entry.ok) begin
                        n_state = S_BASE;
                        n_i = '0;
                        n_acc = '0;
                        n_target = sq[7:2];
                    end else begin
                        n_done = 1'b1;
                        n_omin = '0;
                        n_ogood = '0;
                        n_obad = 1'b1;
                    end
                end
            end
            S_BASE: begin
                n_acc = r_acc + {2'b0, cnt_gt};
                n_i = r_i + 4'd1;
                if ({1'b0, r_i} == i_size - 5'd1) begin
                    n_state = S_SCAN;
                    n_col0 = n_acc;
                    n_cur = n_acc;
                    n_a = '0;
                    n_s = '0;
                    n_min = MIN_INIT;
                    n_good = '0;
                end
            end
            S_SCAN: begin
                n_min = emin;
                n_good = egood;
                if ({1'b0, r_s} != i_size - 5'd1) begin
                    n_s = r_s + 4'd1;
                    n_cur = cur_step[6:0];
                end else if ({1'b0, r_a} != i_size - 5'd1) begin
                    n_a = r_a + 4'd1;
                    n_s = '0;
                    n_col0 = col_step[6:0];
                    n_cur = col_step[6:0];
                end else begin
                    n_state = S_LOAD;
                    n_done = 1'b1;
                    n_omin = emin;
                    n_ogood = egood;
                    n_obad = 1'b0;
                    n_total = (r_total == SAT48) ? r_total : r_total + 48'd1;
                    if (emin > r_best) begin
                        n_best = emin;
                        n_bcnt = 48'd1;
                    end else if (emin == r_best) begin
                        n_bcnt = (r_bcnt == SAT48) ? r_bcnt : r_bcnt + 48'd1;
                    end
                    if (egood < r_fewest) begin
                        n_fewest = egood;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
        if (i_clear) begin
            n_best = '0;
            n_bcnt = '0;
            n_fewest = FEWEST_NONE;
            n_total = '0;
        end
    end

    // permutation and inverse stores
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.wr) begin
            r_perm[i_entry.idx] <= i_entry.value;
            r_inv[i_entry.value] <= i_entry.idx;
        end
    end

    // control and aggregate registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_done <= 1'b0;
            r_best <= '0;
            r_bcnt <= '0;
            r_fewest <= FEWEST_NONE;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_done <= n_done;
            r_best <= n_best;
            r_bcnt <= n_bcnt;
            r_fewest <= n_fewest;
            r_total <= n_total;
        end
    end

    // scan datapath registers
    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_a <= n_a;
        r_s <= n_s;
        r_acc <= n_acc;
        r_col0 <= n_col0;
        r_cur <= n_cur;
        r_min <= n_min;
        r_good <= n_good;
        r_target <= n_target;
        r_omin <= n_omin;
        r_ogood <= n_ogood;
        r_obad <= n_obad;
    end

    assign o_done = r_done;
    assign o_min_inversions = r_omin;
    assign o_good_cut_count = r_ogood;
    assign o_best_min_inversions = r_best;
    assign o_best_count = r_bcnt;
    assign o_fewest_good_cuts = r_fewest;
    assign o_permutations_seen = r_total;
    assign o_bad_permutation = r_obad;

`ifndef NO_ASSERTIONS
    // a result never leaves straight from the base count pass
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) != S_BASE)
        else $error("result after base pass");
    // scan indexes stay inside the permutation length
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_a} < i_size) && ({1'b0, r_s} < i_size))
        else $error("scan index out of range");
    // a good result holds counts inside their ranges
    a_min_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && !r_obad) |-> (r_omin <= 7'd120) && (r_ogood <= 9'd256))
        else $error("bad scan result");
    // words are taken from the queue only while loading
    a_pop_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_LOAD) && !i_empty)
        else $error("pop outside load");
`endif

endmodule
